// ----- rtl/sorted_table_binary_search_macros.svh -----
// Assertion macros for the sorted table search block
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
`define STS_CHECK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sts check failed");
`define STS_CHECK_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sts check failed");
`else
`define STS_CHECK(lbl, clk, rstn, prop)
`define STS_CHECK_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- rtl/sts_pkg.sv -----
// Shared constants and types for the sorted table search block
package sts_pkg;
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int DATA_W = 32;
    localparam int POS_W = 4;
    localparam int STAT_W = 3;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_APPENDED = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic              valid;
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
    } t_res;

    // upper middle of the window [lo, top)
    function automatic logic [IDX_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                                input logic [CNT_W-1:0] top);
        logic [CNT_W:0] sum;
        sum = {1'b0, lo} + {1'b0, top};
        return IDX_W'(sum[CNT_W:1]);
    endfunction
endpackage

// ----- rtl/sts_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data
module sts_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/sts_ctrl.sv -----
// Command sequencer: table fill count, append writes and binary search probes
`include "sorted_table_binary_search_macros.svh"
module sts_ctrl
    import sts_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_command,
    input  logic signed [DATA_W-1:0] i_operand_value,
    input  logic                     i_slot_free,
    output t_res                     o_res
);
    localparam logic S_IDLE  = 1'b0;
    localparam logic S_PROBE = 1'b1;

    logic                     r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_lo, n_lo;
    logic [CNT_W-1:0]         r_top, n_top;
    logic [IDX_W-1:0]         r_mid, n_mid;
    logic signed [DATA_W-1:0] r_key, n_key;

    logic                     accept;
    logic                     we;
    logic                     re;
    logic [IDX_W-1:0]         raddr;
    logic signed [DATA_W-1:0] rdata;
    logic [CNT_W-1:0]         step_lo, step_top;

    sts_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(DATA_W), .AW(IDX_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (IDX_W'(r_count)),
        .i_wdata (i_operand_value),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_ready = (r_state == S_IDLE) && i_slot_free;
    assign accept  = i_valid && o_ready;

    // narrow the window around the probe just read
    always_comb begin
        step_lo  = r_lo;
        step_top = r_top;
        if (r_key < rdata) begin
            step_top = CNT_W'(r_mid);
        end else begin
            step_lo = CNT_W'(r_mid) + CNT_W'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_lo    = r_lo;
        n_top   = r_top;
        n_mid   = r_mid;
        n_key   = r_key;
        we      = 1'b0;
        re      = 1'b0;
        raddr   = r_mid;
        o_res   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_command)
                        CMD_CLEAR: begin
                            n_count      = '0;
                            o_res.valid  = 1'b1;
                            o_res.status = ST_CLEARED;
                        end
                        CMD_APPEND: begin
                            o_res.valid = 1'b1;
                            if (r_count >= CNT_W'(MAX_ENTRIES)) begin
                                o_res.status = ST_FULL;
                            end else begin
                                we           = 1'b1;
                                n_count      = r_count + CNT_W'(1);
                                o_res.status = ST_APPENDED;
                            end
                        end
                        CMD_SEARCH: begin
                            if (r_count == '0) begin
                                o_res.valid  = 1'b1;
                                o_res.status = ST_NOTFOUND;
                            end else begin
                                n_lo    = '0;
                                n_top   = r_count;
                                n_mid   = mid_of('0, r_count);
                                raddr   = n_mid;
                                re      = 1'b1;
                                n_key   = i_operand_value;
                                n_state = S_PROBE;
                            end
                        end
                        default: begin
                            // unused code: drop the item
                        end
                    endcase
                end
            end
            S_PROBE: begin
                if (r_key == rdata) begin
                    o_res.valid    = 1'b1;
                    o_res.status   = ST_FOUND;
                    o_res.position = POS_W'(r_mid);
                    n_state        = S_IDLE;
                end else if (step_lo >= step_top) begin
                    o_res.valid  = 1'b1;
                    o_res.status = ST_NOTFOUND;
                    n_state      = S_IDLE;
                end else begin
                    n_lo  = step_lo;
                    n_top = step_top;
                    n_mid = mid_of(step_lo, step_top);
                    raddr = n_mid;
                    re    = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_top <= n_top;
        r_mid <= n_mid;
        r_key <= n_key;
    end

    `STS_CHECK(a_res_has_slot, i_clk, i_rst_n, o_res.valid |-> i_slot_free)
    `STS_CHECK(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(MAX_ENTRIES))
    `STS_CHECK(a_probe_window, i_clk, i_rst_n,
        (r_state == S_PROBE) |-> ((r_lo < r_top) && (CNT_W'(r_mid) < r_top)
            && (CNT_W'(r_mid) >= r_lo)))
    `STS_CHECK_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE))
endmodule

// ----- rtl/sorted_table_binary_search.sv -----
// Top level of the sorted table search block with its result register
// Clear and append hand their result to the result register in the cycle that
// they are taken. A search issues the first table read when it is taken and then
// makes at most log2(MAX_ENTRIES) + 1 probes; the single read port of the table
// memory, registered, sets the pace of one probe a cycle. An item is taken
// only while no search is running and the result register is free or being
// emptied in the same cycle. Unused command codes are taken and give no result.
// Table contents are not cleared at reset; only the fill count is.
module sorted_table_binary_search
    import sts_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_command,
    input  logic signed [DATA_W-1:0] i_operand_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [STAT_W-1:0]        o_status,
    output logic [POS_W-1:0]         o_position
);
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [POS_W-1:0]  r_position;
    logic              slot_free;
    t_res              res;

    assign slot_free = !r_out_valid || i_ready;

    sts_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_operand_value (i_operand_value),
        .i_slot_free     (slot_free),
        .o_res           (res)
    );

    // hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_status   <= res.status;
            r_position <= res.position;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_status;
    assign o_position = r_position;
endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the sorted table search block: scoreboard and random traffic
`timescale 1ns / 1ps

import sts_pkg::*;

typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
} t_search_outcome;

class search_scoreboard;
    logic signed [DATA_W-1:0] entries [MAX_ENTRIES];
    int                       fill;
    t_search_outcome          awaited_q [$];
    int                       fail_count;
    int                       tally [8];

    function new();
        fill = 0;
        fail_count = 0;
        foreach (tally[i]) tally[i] = 0;
    endfunction

    function int pending();
        return awaited_q.size();
    endfunction

    // Work out the answer to one accepted item and queue it
    function void note_item(input logic [1:0] cmd, input logic signed [DATA_W-1:0] operand);
        t_search_outcome want;
        int lo, hi, mid;
        bit hit;
        want.status = ST_NOTFOUND;
        want.position = '0;
        case (cmd)
            CMD_CLEAR: begin
                fill = 0;
                want.status = ST_CLEARED;
            end
            CMD_APPEND: begin
                if (fill >= MAX_ENTRIES) begin
                    want.status = ST_FULL;
                end else begin
                    entries[fill] = operand;
                    fill++;
                    want.status = ST_APPENDED;
                end
            end
            CMD_SEARCH: begin
                lo = 0;
                hi = fill - 1;
                hit = 1'b0;
                // probe the upper middle; stop on the first match
                while (!hit && lo <= hi) begin
                    mid = (lo + hi + 1) / 2;
                    if (operand == entries[mid]) begin
                        hit = 1'b1;
                        want.status = ST_FOUND;
                        want.position = POS_W'(mid);
                    end else if (operand < entries[mid]) begin
                        hi = mid - 1;
                    end else begin
                        lo = mid + 1;
                    end
                end
            end
            default: return;
        endcase
        awaited_q.push_back(want);
    endfunction

    task flag_mismatch(input string what);
        fail_count++;
        if (fail_count <= 100) $display("mismatch: %s", what);
    endtask

    task check_result(input logic [STAT_W-1:0] status, input logic [POS_W-1:0] position);
        t_search_outcome want;
        if (awaited_q.size() == 0) begin
            flag_mismatch($sformatf("status %0d position %0d arrived with nothing outstanding",
                                    status, position));
            return;
        end
        want = awaited_q.pop_front();
        tally[want.status]++;
        if (status !== want.status)
            flag_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
        if (position !== want.position)
            flag_mismatch($sformatf("position %0d, wanted %0d (status %0d)",
                                    position, want.position, want.status));
    endtask
endclass

module testbench;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 800;
    localparam int CYCLE_LIMIT = 400000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [1:0]               i_command = CMD_CLEAR;
    logic signed [DATA_W-1:0] i_operand_value = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [STAT_W-1:0]        o_status;
    logic [POS_W-1:0]         o_position;

    search_scoreboard sb = new();
    int  sent_count = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;

    logic signed [DATA_W-1:0] ladder [MAX_ENTRIES] = '{
        32'sh8000_0000, -32'sd1000, -32'sd1000, -32'sd1, 32'sd0, 32'sd1, 32'sd5, 32'sd5,
        32'sd5, 32'sd100, 32'sd1000, 32'sh0010_0000, 32'sh4000_0000, 32'sh7FFF_FFFE,
        32'sh7FFF_FFFF, 32'sh7FFF_FFFF
    };

    sorted_table_binary_search dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_operand_value (i_operand_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_position      (o_position)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: check what is taken, then stall now and again
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_status, o_position);
        i_ready <= calm || ($urandom_range(99) >= 6);
    end

    task automatic send_item(input logic [1:0] cmd, input logic signed [DATA_W-1:0] operand);
        if (!calm && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 30);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_operand_value <= operand;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(cmd, operand);
        if (cmd != CMD_UNUSED) sent_count++;
    endtask

    // Hold off the sender until every outstanding result is back
    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Clear, load a table (ascending or not), then search it
    task automatic run_burst(input bit ascending);
        logic signed [DATA_W-1:0] vals [MAX_ENTRIES];
        logic signed [DATA_W-1:0] v;
        int n, stored, pos, mode, pick;
        n = $urandom_range(MAX_ENTRIES);
        if ($urandom_range(99) < 20) n = MAX_ENTRIES + $urandom_range(1, 3);
        mode = $urandom_range(2);
        stored = 0;
        send_item(CMD_CLEAR, $urandom);
        for (int i = 0; i < n && i < MAX_ENTRIES; i++) begin
            if (mode == 0) begin
                v = $urandom_range(16);
                v = v - 8;
            end else if (mode == 1) begin
                v = $urandom_range(2000);
                v = v - 1000;
            end else begin
                v = $urandom;
            end
            pos = stored;
            if (ascending) begin
                while (pos > 0 && vals[pos-1] > v) begin
                    vals[pos] = vals[pos-1];
                    pos--;
                end
            end
            vals[pos] = v;
            stored++;
        end
        for (int i = 0; i < stored; i++) send_item(CMD_APPEND, vals[i]);
        // anything past the last slot must be refused
        for (int i = stored; i < n; i++) send_item(CMD_APPEND, $urandom);
        repeat ($urandom_range(1, 8)) begin
            pick = $urandom_range(99);
            if (stored == 0 || pick >= 75) begin
                v = $urandom;
            end else begin
                v = vals[$urandom_range(stored - 1)];
                if (pick >= 50) v = pick[0] ? v + 1 : v - 1;
            end
            send_item(CMD_SEARCH, v);
        end
    endtask

    initial begin
        int kind;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(CMD_SEARCH, 32'sd0);
        send_item(CMD_CLEAR, 32'shFFFF_FFFF);
        send_item(CMD_UNUSED, 32'sh1234_5678);
        foreach (ladder[i]) send_item(CMD_APPEND, ladder[i]);
        send_item(CMD_APPEND, 32'sd7);
        send_item(CMD_SEARCH, 32'sh8000_0000);
        send_item(CMD_SEARCH, 32'sh7FFF_FFFF);
        send_item(CMD_SEARCH, 32'sd5);
        send_item(CMD_SEARCH, 32'sd6);
        send_item(CMD_SEARCH, -32'sd1000);
        wait_for_results();

        while (sent_count < ITEM_TARGET) begin
            calm <= (sent_count >= 300 && sent_count < 450);
            kind = $urandom_range(99);
            if (kind < 75) begin
                run_burst(1'b1);
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 6)) send_item(2'($urandom_range(3)), $urandom);
            end else begin
                run_burst(1'b0);
            end
            if ($urandom_range(7) == 0) wait_for_results();
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d items: %0d clears, %0d appends, %0d refused on a full table,",
                 sent_count, sb.tally[ST_CLEARED], sb.tally[ST_APPENDED], sb.tally[ST_FULL]);
        $display("  %0d searches that hit and %0d that missed, %0d mismatches.",
                 sb.tally[ST_FOUND], sb.tally[ST_NOTFOUND], sb.fail_count);
        if (sb.fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
